### hw/rtl/gmpc_pkg.sv
// gmpc_pkg: shared types and constants for the grid min-path cost engine.
// Used by gmpc_cost_ram, gmpc_solver and grid_min_path_cost_engine.
`default_nettype none

package gmpc_pkg;

  localparam int COST_W     = 24;
  localparam int CFG_DATA_W = 7;
  localparam int DIM_W      = 9;   // holds a dimension count up to 511

  localparam logic [COST_W-1:0] COST_MAX = 24'hFF_FFFF;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_SOLVE = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CFG_ROWS = 2'd0,
    CFG_COLS = 2'd1,
    CFG_MODE = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRIME,
    S_CELL_RD,
    S_CELL_WR,
    S_SCAN,
    S_SCAN_END,
    S_DONE
  } slv_state_t;

  // memory access strobes from one requester
  typedef struct packed {
    logic rd_a_en;
    logic rd_b_en;
    logic wr_en;
  } mem_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } slv_stat_t;

endpackage

`default_nettype wire

### hw/rtl/grid_min_path_cost_engine.sv
// grid_min_path_cost_engine: top level; config registers, word handshakes,
// result register. Uses gmpc_pkg, gmpc_cost_ram and gmpc_solver.
//
//   channel   dir  handshake              payload
//   -------   ---  ---------------------  ------------------------------------
//   cfg       in   cfg_valid / cfg_ready  cfg_index, cfg_data (7 bits)
//   in        in   in_valid / in_ready    opcode, row_index, col_index,
//                                         cell_value
//   out       out  out_valid / out_ready  cost_value, is_solve_answer
//
// Loads and reads take one word per cycle while in_ready is high; a read answer
// reaches the output register through the RAM's registered port.
// A solve visits each cell as a read state plus a write state on the cost RAM;
// mode 1 runs the pass, then a scan of the first row. No word is taken
// during a solve. rst is synchronous; it restores rows 1, cols 1, mode 0 and
// empties the pipeline, the grid contents are left as they are. A stalled
// output holds one read answer plus one in flight before in_ready drops.
`default_nettype none

module grid_min_path_cost_engine #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [gmpc_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input words
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       opcode,
  input  logic [5:0]                       row_index,
  input  logic [5:0]                       col_index,
  input  logic [15:0]                      cell_value,
  // results
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [gmpc_pkg::COST_W-1:0]      cost_value,
  output logic                             is_solve_answer
);
  import gmpc_pkg::*;

  localparam int RB    = $clog2(MAX_ROWS);
  localparam int CB    = $clog2(MAX_COLS);
  localparam int AW    = RB + CB;
  localparam int DEPTH = MAX_ROWS * (2 ** CB);   // rows on a power-of-two pitch

  // ---------------- configuration registers ----------------
  logic [CFG_DATA_W-1:0] grid_rows, grid_cols;
  logic                  path_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= CFG_DATA_W'(1);
      grid_cols <= CFG_DATA_W'(1);
      path_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROWS: grid_rows <= cfg_data;
        CFG_COLS: grid_cols <= cfg_data;
        CFG_MODE: path_mode <= cfg_data[0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // Dimensions: zero acts as one, anything above the storage acts as the max.
  logic [DIM_W-1:0] rows_ext, cols_ext, rows_eff, cols_eff;
  logic [DIM_W-1:0] rows_last_full, cols_last_full;
  logic [RB-1:0]    rows_last;
  logic [CB-1:0]    cols_last;

  assign rows_ext = DIM_W'(grid_rows);
  assign cols_ext = DIM_W'(grid_cols);
  assign rows_eff = (grid_rows == '0) ? DIM_W'(1) :
                    (rows_ext > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_ext;
  assign cols_eff = (grid_cols == '0) ? DIM_W'(1) :
                    (cols_ext > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_ext;
  assign rows_last_full = rows_eff - DIM_W'(1);
  assign cols_last_full = cols_eff - DIM_W'(1);
  assign rows_last      = rows_last_full[RB-1:0];
  assign cols_last      = cols_last_full[CB-1:0];

  // ---------------- input decode ----------------
  logic [DIM_W-1:0] row_ext, col_ext;
  logic             in_bounds;
  logic [AW-1:0]    cell_addr;
  logic             accept, out_free, rd_pending, rd_inside, solve_go;
  logic             top_wr, top_rd;
  slv_stat_t        slv_stat;

  assign row_ext   = DIM_W'(row_index);
  assign col_ext   = DIM_W'(col_index);
  assign in_bounds = (row_ext < DIM_W'(MAX_ROWS)) && (col_ext < DIM_W'(MAX_COLS));
  assign cell_addr = {row_ext[RB-1:0], col_ext[CB-1:0]};

  assign out_free = !out_valid || out_ready;
  // one read answer may sit in the RAM output while the result register drains
  assign in_ready = !slv_stat.busy && !solve_go && (!rd_pending || out_free);
  assign accept   = in_valid && in_ready;
  assign top_wr   = accept && (opcode == OP_LOAD) && in_bounds;
  assign top_rd   = accept && (opcode == OP_READ) && in_bounds;

  // ---------------- solver and RAM ----------------
  mem_req_t              slv_req;
  logic [AW-1:0]         slv_rd_a_addr, slv_rd_b_addr, slv_wr_addr;
  logic [COST_W-1:0]     slv_wr_data, slv_answer;
  logic [COST_W-1:0]     ram_rd_a_data, ram_rd_b_data;
  logic                  slv_start, slv_ack;

  // solve waits until a read ahead of it has left the RAM output
  assign slv_start = solve_go && !rd_pending;
  assign slv_ack   = slv_stat.done && !rd_pending && out_free;

  gmpc_solver #(
    .RB (RB),
    .CB (CB)
  ) u_solver (
    .clk       (clk),
    .rst       (rst),
    .start     (slv_start),
    .ack       (slv_ack),
    .path_mode (path_mode),
    .rows_last (rows_last),
    .cols_last (cols_last),
    .rd_a_data (ram_rd_a_data),
    .rd_b_data (ram_rd_b_data),
    .req       (slv_req),
    .rd_a_addr (slv_rd_a_addr),
    .rd_b_addr (slv_rd_b_addr),
    .wr_addr   (slv_wr_addr),
    .wr_data   (slv_wr_data),
    .stat      (slv_stat),
    .answer    (slv_answer)
  );

  gmpc_cost_ram #(
    .AW    (AW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk       (clk),
    .wr_en     (slv_req.wr_en | top_wr),
    .wr_addr   (slv_stat.busy ? slv_wr_addr : cell_addr),
    .wr_data   (slv_stat.busy ? slv_wr_data : COST_W'(cell_value)),
    .rd_a_en   (slv_req.rd_a_en | top_rd),
    .rd_a_addr (slv_stat.busy ? slv_rd_a_addr : cell_addr),
    .rd_a_data (ram_rd_a_data),
    .rd_b_en   (slv_req.rd_b_en),
    .rd_b_addr (slv_rd_b_addr),
    .rd_b_data (ram_rd_b_data)
  );

  // ---------------- control flags ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
      solve_go   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept && (opcode == OP_READ)) begin
        rd_pending <= 1'b1;
      end else if (out_free) begin
        rd_pending <= 1'b0;
      end

      if (accept && (opcode == OP_SOLVE)) begin
        solve_go <= 1'b1;
      end else if (slv_start) begin
        solve_go <= 1'b0;
      end

      if ((rd_pending && out_free) || slv_ack) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (accept && (opcode == OP_READ)) begin
      rd_inside <= in_bounds;
    end
    if (rd_pending && out_free) begin
      cost_value      <= rd_inside ? ram_rd_a_data : '0;
      is_solve_answer <= 1'b0;
    end else if (slv_ack) begin
      cost_value      <= slv_answer;
      is_solve_answer <= 1'b1;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/gmpc_cost_ram.sv
// gmpc_cost_ram: cost grid storage, one write port and two registered read ports.
// Depends on gmpc_pkg for the cost width.
`default_nettype none

module gmpc_cost_ram #(
  parameter int AW    = 12,
  parameter int DEPTH = 4096
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [gmpc_pkg::COST_W-1:0]  wr_data,
  input  logic                         rd_a_en,
  input  logic [AW-1:0]                rd_a_addr,
  output logic [gmpc_pkg::COST_W-1:0]  rd_a_data,
  input  logic                         rd_b_en,
  input  logic [AW-1:0]                rd_b_addr,
  output logic [gmpc_pkg::COST_W-1:0]  rd_b_data
);
  import gmpc_pkg::*;

  logic [COST_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_a_en) begin
      rd_a_data <= mem[rd_a_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_b_en) begin
      rd_b_data <= mem[rd_b_addr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/gmpc_solver.sv
// gmpc_solver: sequencer for the in-place backward pass over the cost RAM.
// Depends on gmpc_pkg (state enum, request and status structs).
`default_nettype none

module gmpc_solver #(
  parameter int RB = 6,
  parameter int CB = 6
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         ack,
  input  logic                         path_mode,
  input  logic [RB-1:0]                rows_last,
  input  logic [CB-1:0]                cols_last,
  input  logic [gmpc_pkg::COST_W-1:0]  rd_a_data,
  input  logic [gmpc_pkg::COST_W-1:0]  rd_b_data,
  output gmpc_pkg::mem_req_t           req,
  output logic [RB+CB-1:0]             rd_a_addr,
  output logic [RB+CB-1:0]             rd_b_addr,
  output logic [RB+CB-1:0]             wr_addr,
  output logic [gmpc_pkg::COST_W-1:0]  wr_data,
  output gmpc_pkg::slv_stat_t          stat,
  output logic [gmpc_pkg::COST_W-1:0]  answer
);
  import gmpc_pkg::*;

  slv_state_t state, state_next;
  logic [RB-1:0] r, r_next;
  logic [CB-1:0] c, c_next;
  logic [COST_W-1:0] last_sum;   // cell just written (right neighbor in mode 0)
  logic [COST_W-1:0] win_mid;    // row below, same column
  logic [COST_W-1:0] win_right;  // row below, column to the right
  logic [COST_W-1:0] best;
  logic scan_valid;

  logic [RB-1:0] r_inc, r_dec;
  logic [CB-1:0] c_inc, c_dec;
  logic has_right, has_down, has_left;
  logic [COST_W-1:0] step, step_a;
  logic [COST_W:0]   sum_wide;
  logic [COST_W-1:0] sum;

  assign r_inc = r + RB'(1);
  assign r_dec = r - RB'(1);
  assign c_inc = c + CB'(1);
  assign c_dec = c - CB'(1);

  assign has_right = (c != cols_last);
  assign has_down  = (r != rows_last);
  assign has_left  = (c != '0);

  // step cost for the cell under update
  always_comb begin
    step   = '0;
    step_a = '0;
    if (!path_mode) begin
      if (has_right && has_down) begin
        step = (last_sum < rd_b_data) ? last_sum : rd_b_data;
      end else if (has_right) begin
        step = last_sum;
      end else if (has_down) begin
        step = rd_b_data;
      end
    end else begin
      step_a = win_mid;
      if (has_left && (rd_b_data < step_a)) begin
        step_a = rd_b_data;
      end
      step = step_a;
      if (has_right && (win_right < step_a)) begin
        step = win_right;
      end
    end
  end

  assign sum_wide = {1'b0, rd_a_data} + {1'b0, step};
  assign sum      = sum_wide[COST_W] ? COST_MAX : sum_wide[COST_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      scan_valid <= 1'b0;
    end else begin
      state      <= state_next;
      scan_valid <= (state == S_SCAN);
    end
  end

  always_comb begin
    state_next = state;
    r_next     = r;
    c_next     = c;
    req        = '0;
    rd_a_addr  = {r, c};
    rd_b_addr  = {r_inc, c};
    wr_addr    = {r, c};
    wr_data    = sum;
    case (state)
      S_IDLE: begin
        if (start) begin
          c_next = cols_last;
          if (!path_mode) begin
            r_next     = rows_last;
            state_next = S_CELL_RD;
          end else if (rows_last == '0) begin
            c_next     = '0;
            state_next = S_SCAN;
          end else begin
            r_next     = rows_last - RB'(1);
            state_next = S_PRIME;
          end
        end
      end
      S_PRIME: begin
        req.rd_b_en = 1'b1;
        rd_b_addr   = {r_inc, cols_last};
        state_next  = S_CELL_RD;
      end
      S_CELL_RD: begin
        req.rd_a_en = 1'b1;
        if (!path_mode) begin
          req.rd_b_en = has_down;
          rd_b_addr   = {r_inc, c};
        end else begin
          req.rd_b_en = has_left;
          rd_b_addr   = {r_inc, c_dec};
        end
        state_next = S_CELL_WR;
      end
      S_CELL_WR: begin
        req.wr_en = 1'b1;
        if (c != '0) begin
          c_next     = c_dec;
          state_next = S_CELL_RD;
        end else if (r != '0) begin
          r_next     = r_dec;
          c_next     = cols_last;
          state_next = path_mode ? S_PRIME : S_CELL_RD;
        end else if (path_mode) begin
          c_next     = '0;
          state_next = S_SCAN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        req.rd_a_en = 1'b1;
        rd_a_addr   = {RB'(0), c};
        if (c == cols_last) begin
          state_next = S_SCAN_END;
        end else begin
          c_next = c_inc;
        end
      end
      S_SCAN_END: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (ack) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    r <= r_next;
    c <= c_next;
    // row start in mode 1: primed read of the row below is ready now
    if ((state == S_CELL_RD) && path_mode && (c == cols_last)) begin
      win_mid <= rd_b_data;
    end
    if (state == S_CELL_WR) begin
      last_sum  <= sum;
      win_right <= win_mid;
      win_mid   <= rd_b_data;
    end
    if (state == S_IDLE) begin
      best <= COST_MAX;
    end else if (scan_valid && (rd_a_data < best)) begin
      best <= rd_a_data;
    end
  end

  assign stat.busy = (state != S_IDLE);
  assign stat.done = (state == S_DONE);
  assign answer    = path_mode ? best : last_sum;

endmodule

`default_nettype wire
